// ===== design/mi4_pkg.sv =====
// Shared types, widths and index helpers for the 4x4 matrix inverse.
`timescale 1ns / 1ps
package mi4_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int ELEM_W = 32;
   localparam int COF_W = 64;
   localparam int PROD_W = 65;
   localparam int ACC_W = 100;
   localparam int DM_W = 97;
   localparam int QUO_W = 32;
   localparam int NUM_W = DM_W + QUO_W;

   typedef enum logic [4:0] {
      ST_LOAD,
      ST_RDA,
      ST_RDB,
      ST_RDC,
      ST_MAB,
      ST_MLO,
      ST_MHI,
      ST_SUM,
      ST_ACC,
      ST_RND1,
      ST_RND2,
      ST_RND3,
      ST_DRD,
      ST_DLO,
      ST_DHI,
      ST_DSUM,
      ST_DACC,
      ST_DABS,
      ST_ODS,
      ST_OPR,
      ST_DIVW
   } seq_state_type;

   typedef enum logic [1:0] {
      DV_IDLE,
      DV_RUN,
      DV_RND,
      DV_DONE
   } div_state_type;

   typedef struct packed {
      logic done;
      logic big;
   } div_stat_type;

   // Column order of the k-th product of a 3x3 minor, packed {n2, n1, n0}.
   function automatic logic [1:0] perm_sel(input logic [2:0] k, input logic [1:0] n);
      logic [2:0][1:0] t;
      case (k)
         3'd0: t = {2'd2, 2'd1, 2'd0};
         3'd1: t = {2'd0, 2'd2, 2'd1};
         3'd2: t = {2'd1, 2'd0, 2'd2};
         3'd3: t = {2'd1, 2'd2, 2'd0};
         3'd4: t = {2'd0, 2'd1, 2'd2};
         3'd5: t = {2'd2, 2'd0, 2'd1};
         default: t = {2'd2, 2'd1, 2'd0};
      endcase
      return t[n];
   endfunction

   // Store address of factor n of term k of the minor for cofactor (r, c).
   function automatic logic [3:0] minor_addr(input logic [1:0] r, input logic [1:0] c,
                                             input logic [2:0] k, input logic [1:0] n);
      logic [1:0] row;
      logic [1:0] sel;
      logic [1:0] col;
      row = (n < c) ? n : n + 2'd1;
      sel = perm_sel(k, n);
      col = (sel < r) ? sel : sel + 2'd1;
      return {row, col};
   endfunction

endpackage

// ===== design/mi4_mul.sv =====
// Shared registered signed 33x32 multiplier.
`timescale 1ns / 1ps
module mi4_mul
   import mi4_pkg::*;
(
   input  logic                     clock,
   input  logic signed [ELEM_W:0]   mul_a,
   input  logic signed [ELEM_W-1:0] mul_b,
   output logic signed [PROD_W-1:0] mul_q
);

   logic signed [PROD_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= PROD_W'(mul_a * mul_b);
   end

   assign mul_q = prod_ff;

endmodule

// ===== design/mi4_div.sv =====
// Restoring radix-2 divider: 32 quotient bits, round half up, overflow precheck.
`timescale 1ns / 1ps
module mi4_div
   import mi4_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [NUM_W-1:0]   num,
   input  logic [DM_W-1:0]    den,
   output div_stat_type       stat,
   output logic [QUO_W:0]     quo
);

   div_state_type        state_ff;
   div_state_type        state_in;
   logic [DM_W:0]        rem_ff;
   logic [QUO_W-1:0]     nlo_ff;
   logic [QUO_W-1:0]     q_ff;
   logic [DM_W-1:0]      den_ff;
   logic [5:0]           cnt_ff;
   logic                 big_ff;
   logic [QUO_W:0]       quo_ff;
   logic [DM_W:0]        rs;
   logic                 ge;
   logic                 is_big;

   assign is_big = num >= {den, {QUO_W{1'b0}}};
   assign rs = {rem_ff[DM_W-1:0], nlo_ff[QUO_W-1]};
   assign ge = rs >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DV_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         DV_IDLE: begin
            if (start) begin
               state_in = is_big ? DV_DONE : DV_RUN;
            end
         end
         DV_RUN: begin
            if (cnt_ff == 6'd1) begin
               state_in = DV_RND;
            end
         end
         DV_RND: state_in = DV_DONE;
         DV_DONE: state_in = DV_IDLE;
         default: state_in = DV_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         DV_IDLE: begin
            if (start) begin
               big_ff <= is_big;
               rem_ff <= {1'b0, num[NUM_W-1:QUO_W]};
               nlo_ff <= num[QUO_W-1:0];
               den_ff <= den;
               cnt_ff <= 6'(QUO_W);
               q_ff <= '0;
            end
         end
         DV_RUN: begin
            rem_ff <= ge ? rs - {1'b0, den_ff} : rs;
            nlo_ff <= {nlo_ff[QUO_W-2:0], 1'b0};
            q_ff <= {q_ff[QUO_W-2:0], ge};
            cnt_ff <= cnt_ff - 6'd1;
         end
         DV_RND: begin
            quo_ff <= {1'b0, q_ff} +
                      (QUO_W+1)'({rem_ff, 1'b0} >= {2'b00, den_ff});
         end
         default: begin
         end
      endcase
   end

   assign stat.done = (state_ff == DV_DONE);
   assign stat.big = big_ff;
   assign quo = quo_ff;

endmodule

// ===== design/matrix_inverse_4x4_top.sv =====
// 4x4 matrix inverse by adjugate, signed fixed point, one shared multiplier.
// Load: one element beat per cycle; the first fifteen only store.
// After the sixteenth beat: the cofactors, one after another on the shared
// multiplier, then the determinant, then each result on the divider.
// Singular matrix: results skip the divider. busy stays high until the last result.
// Synchronous reset returns to load state at element zero.
`timescale 1ns / 1ps
module matrix_inverse_4x4_top
   import mi4_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic signed [ELEM_W-1:0] req_element,
   output logic                     rsp_valid,
   output logic signed [ELEM_W-1:0] rsp_result_element,
   output logic                     rsp_singular,
   output logic                     rsp_saturated,
   output logic                     rsp_last
);

   localparam int RND = 2 * FRAC_BITS;

   seq_state_type            state_ff;
   seq_state_type            state_in;
   logic [3:0]               load_cnt_ff;
   logic [3:0]               cof_idx_ff;
   logic [2:0]               k_ff;
   logic [1:0]               dcnt_ff;
   logic [3:0]               out_idx_ff;

   logic [ELEM_W-1:0]        mat_mem [16];
   logic [ELEM_W-1:0]        mat_rd_ff;
   logic [3:0]               mat_addr;
   logic [COF_W-1:0]         cof_mem [16];
   logic [COF_W-1:0]         cof_rd_ff;
   logic [3:0]               cof_addr;
   logic                     cof_we;
   logic [COF_W-1:0]         cof_wdata;
   logic [15:0]              clip_ff;

   logic signed [ELEM_W-1:0] opa_ff;
   logic signed [ELEM_W-1:0] opb_ff;
   logic signed [ELEM_W-1:0] opc_ff;
   logic signed [ELEM_W-1:0] abhi_ff;
   logic signed [PROD_W-1:0] lo_ff;
   logic signed [ACC_W-1:0]  term_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic [ACC_W-1:0]         rmag_ff;
   logic                     rneg_ff;
   logic [DM_W-1:0]          dm_ff;
   logic                     det_neg_ff;
   logic                     det_zero_ff;
   logic                     qneg_ff;

   logic signed [ELEM_W:0]   mul_a;
   logic signed [ELEM_W-1:0] mul_b;
   logic signed [PROD_W-1:0] mul_q;
   logic signed [ACC_W-1:0]  hi_ext;
   logic                     sub_term;
   logic [1:0]               cr;
   logic [1:0]               cc;
   logic                     rnd_over;
   logic [ACC_W-1:0]         acc_abs;
   logic [COF_W-1:0]         cof_abs;
   logic [NUM_W-1:0]         div_num;
   logic                     div_start;
   div_stat_type             div_stat;
   logic [QUO_W:0]           div_quo;
   logic [QUO_W:0]           q_lim;
   logic                     q_over;
   logic [QUO_W-1:0]         q_val;

   logic                     rsp_valid_ff;
   logic [ELEM_W-1:0]        rsp_elem_ff;
   logic                     rsp_sing_ff;
   logic                     rsp_sat_ff;
   logic                     rsp_last_ff;

   assign cr = cof_idx_ff[3:2];
   assign cc = cof_idx_ff[1:0];
   assign sub_term = (k_ff >= 3'd3) ^ cr[0] ^ cc[0];
   assign hi_ext = ACC_W'(mul_q);
   assign acc_abs = acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);
   assign cof_abs = cof_rd_ff[COF_W-1] ? -cof_rd_ff : cof_rd_ff;
   assign div_num = NUM_W'(cof_abs) << RND;
   assign div_start = (state_ff == ST_OPR) && !det_zero_ff;

   assign rnd_over = rneg_ff ? (rmag_ff > ACC_W'(64'h8000_0000_0000_0000))
                             : (rmag_ff > ACC_W'(64'h7FFF_FFFF_FFFF_FFFF));
   assign cof_we = (state_ff == ST_RND3);
   assign cof_wdata = rnd_over ? (rneg_ff ? 64'h8000_0000_0000_0000
                                          : 64'h7FFF_FFFF_FFFF_FFFF)
                               : (rneg_ff ? -rmag_ff[COF_W-1:0] : rmag_ff[COF_W-1:0]);

   assign q_lim = qneg_ff ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
   assign q_over = div_stat.big || (div_quo > q_lim);
   assign q_val = q_over ? q_lim[QUO_W-1:0] : div_quo[QUO_W-1:0];

   mi4_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .mul_q (mul_q)
   );

   mi4_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (dm_ff),
      .stat  (div_stat),
      .quo   (div_quo)
   );

   always_comb begin
      case (state_ff)
         ST_MLO: begin
            mul_a = {1'b0, mul_q[ELEM_W-1:0]};
            mul_b = opc_ff;
         end
         ST_MHI, ST_DHI: begin
            mul_a = {abhi_ff[ELEM_W-1], abhi_ff};
            mul_b = opc_ff;
         end
         ST_DLO: begin
            mul_a = {1'b0, cof_rd_ff[ELEM_W-1:0]};
            mul_b = mat_rd_ff;
         end
         default: begin
            mul_a = {opa_ff[ELEM_W-1], opa_ff};
            mul_b = opb_ff;
         end
      endcase
   end

   always_comb begin
      case (state_ff)
         ST_RDA: mat_addr = minor_addr(cr, cc, k_ff, 2'd0);
         ST_RDB: mat_addr = minor_addr(cr, cc, k_ff, 2'd1);
         ST_RDC: mat_addr = minor_addr(cr, cc, k_ff, 2'd2);
         ST_DRD: mat_addr = {2'b00, dcnt_ff};
         ST_ODS: mat_addr = out_idx_ff;
         default: mat_addr = '0;
      endcase
      case (state_ff)
         ST_DRD: cof_addr = {dcnt_ff, 2'b00};
         ST_ODS: cof_addr = out_idx_ff;
         default: cof_addr = cof_idx_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_LOAD && start) begin
         mat_mem[load_cnt_ff] <= req_element;
      end
      mat_rd_ff <= mat_mem[mat_addr];
   end

   always_ff @(posedge clock) begin
      if (cof_we) begin
         cof_mem[cof_idx_ff] <= cof_wdata;
      end
      cof_rd_ff <= cof_mem[cof_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (start && load_cnt_ff == 4'd15) begin
               state_in = ST_RDA;
            end
         end
         ST_RDA: state_in = ST_RDB;
         ST_RDB: state_in = ST_RDC;
         ST_RDC: state_in = ST_MAB;
         ST_MAB: state_in = ST_MLO;
         ST_MLO: state_in = ST_MHI;
         ST_MHI: state_in = ST_SUM;
         ST_SUM: state_in = ST_ACC;
         ST_ACC: state_in = (k_ff == 3'd5) ? ST_RND1 : ST_RDA;
         ST_RND1: state_in = ST_RND2;
         ST_RND2: state_in = ST_RND3;
         ST_RND3: state_in = (cof_idx_ff == 4'd15) ? ST_DRD : ST_RDA;
         ST_DRD: state_in = ST_DLO;
         ST_DLO: state_in = ST_DHI;
         ST_DHI: state_in = ST_DSUM;
         ST_DSUM: state_in = ST_DACC;
         ST_DACC: state_in = (dcnt_ff == 2'd3) ? ST_DABS : ST_DRD;
         ST_DABS: state_in = ST_ODS;
         ST_ODS: state_in = ST_OPR;
         ST_OPR: begin
            if (!det_zero_ff) begin
               state_in = ST_DIVW;
            end else begin
               state_in = (out_idx_ff == 4'd15) ? ST_LOAD : ST_ODS;
            end
         end
         ST_DIVW: begin
            if (div_stat.done) begin
               state_in = (out_idx_ff == 4'd15) ? ST_LOAD : ST_ODS;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_cnt_ff <= '0;
         cof_idx_ff <= '0;
         k_ff <= '0;
         dcnt_ff <= '0;
         out_idx_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_LOAD: begin
               if (start) begin
                  load_cnt_ff <= load_cnt_ff + 4'd1;
                  cof_idx_ff <= '0;
                  k_ff <= '0;
                  acc_ff <= '0;
               end
            end
            ST_RDB: opa_ff <= mat_rd_ff;
            ST_RDC: opb_ff <= mat_rd_ff;
            ST_MAB: opc_ff <= mat_rd_ff;
            ST_MLO: abhi_ff <= mul_q[2*ELEM_W-1:ELEM_W];
            ST_MHI: lo_ff <= mul_q;
            ST_SUM: term_ff <= (hi_ext <<< ELEM_W) + ACC_W'(lo_ff);
            ST_ACC: begin
               acc_ff <= sub_term ? acc_ff - term_ff : acc_ff + term_ff;
               k_ff <= (k_ff == 3'd5) ? 3'd0 : k_ff + 3'd1;
            end
            ST_RND1: begin
               rmag_ff <= acc_abs;
               rneg_ff <= acc_ff[ACC_W-1];
            end
            ST_RND2: rmag_ff <= (rmag_ff + (ACC_W'(1) << (RND - 1))) >> RND;
            ST_RND3: begin
               clip_ff[cof_idx_ff] <= rnd_over;
               cof_idx_ff <= cof_idx_ff + 4'd1;
               acc_ff <= '0;
               dcnt_ff <= '0;
            end
            ST_DLO: begin
               opc_ff <= mat_rd_ff;
               abhi_ff <= cof_rd_ff[COF_W-1:ELEM_W];
            end
            ST_DHI: lo_ff <= mul_q;
            ST_DSUM: term_ff <= (hi_ext <<< ELEM_W) + ACC_W'(lo_ff);
            ST_DACC: begin
               acc_ff <= acc_ff + term_ff;
               dcnt_ff <= dcnt_ff + 2'd1;
            end
            ST_DABS: begin
               dm_ff <= acc_abs[DM_W-1:0];
               det_neg_ff <= acc_ff[ACC_W-1];
               det_zero_ff <= (acc_ff == '0);
               out_idx_ff <= '0;
            end
            ST_OPR: begin
               qneg_ff <= cof_rd_ff[COF_W-1] ^ det_neg_ff;
               if (det_zero_ff) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_elem_ff <= mat_rd_ff;
                  rsp_sing_ff <= 1'b1;
                  rsp_sat_ff <= 1'b0;
                  rsp_last_ff <= (out_idx_ff == 4'd15);
                  out_idx_ff <= out_idx_ff + 4'd1;
               end
            end
            ST_DIVW: begin
               if (div_stat.done) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_elem_ff <= qneg_ff ? -q_val : q_val;
                  rsp_sing_ff <= 1'b0;
                  rsp_sat_ff <= q_over || clip_ff[out_idx_ff];
                  rsp_last_ff <= (out_idx_ff == 4'd15);
                  out_idx_ff <= out_idx_ff + 4'd1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign busy = (state_ff != ST_LOAD);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_result_element = rsp_elem_ff;
   assign rsp_singular = rsp_sing_ff;
   assign rsp_saturated = rsp_sat_ff;
   assign rsp_last = rsp_last_ff;

endmodule
